>>> hdl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants
// Character codes, digit counts and the queue entry that carries one
// converted number from the front to the back of the decimal printer.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int MAX_DIGITS  = 10;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int QUEUE_DEPTH_DEF = 2;

  // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP10_SH
  localparam logic [VALUE_W-1:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int                 RECIP10_SH = 35;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // One converted number: sign, digit count, digits least significant first
  typedef struct packed {
    logic                                neg;
    logic [CNT_W-1:0]                    cnt;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits;
  } sida_entry_t;

endpackage

>>> hdl/sida_front.sv
// ----------------------------------------------------------------------------
// sida_front: command intake and digit extraction
// Accepts one signed value, forms its magnitude and peels off one decimal
// digit per cycle, then pushes the finished number into the queue.
// ----------------------------------------------------------------------------
module sida_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [sida_pkg::VALUE_W-1:0]      in_value,
  output logic                              busy,
  output logic                              push,
  output sida_pkg::sida_entry_t             push_entry,
  input  logic                              q_full
);
  import sida_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  front_state_t                        state_r, state_nxt;
  logic                                neg_r, neg_nxt;
  logic [VALUE_W-1:0]                  mag_r, mag_nxt;
  logic [CNT_W-1:0]                    nd_r, nd_nxt;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_r, digits_nxt;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   rem;
  logic                 accept;

  // Divide the magnitude by ten through the reciprocal
  assign prod = {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP10};
  assign quot = {{(RECIP10_SH-VALUE_W){1'b0}}, prod[2*VALUE_W-1:RECIP10_SH]};
  assign rem  = mag_r - (quot << 3) - (quot << 1);

  assign busy       = (state_r != F_IDLE);
  assign accept     = start && !busy;
  assign push       = (state_r == F_PUSH) && !q_full;
  assign push_entry = '{neg: neg_r, cnt: nd_r, digits: digits_r};

  // Sequence intake, one digit per cycle, and the push
  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    nd_nxt     = nd_r;
    digits_nxt = digits_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          neg_nxt   = in_value[VALUE_W-1];
          mag_nxt   = in_value[VALUE_W-1] ? (~in_value + 1'b1) : in_value;
          nd_nxt    = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        digits_nxt[nd_r[DIGIT_W-1:0]] = rem[DIGIT_W-1:0];
        nd_nxt  = nd_r + 1'b1;
        mag_nxt = quot;
        if (quot == '0 || nd_r == CNT_W'(MAX_DIGITS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Hold state and the number under conversion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r  <= state_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      nd_r     <= nd_nxt;
      digits_r <= digits_nxt;
    end
  end

`ifndef SYNTHESIS
  a_nd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_CONV) |-> (nd_r < CNT_W'(MAX_DIGITS)))
    else $error("digit count past ten during conversion");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (nd_r != '0))
    else $error("number pushed with no digits");
`endif

endmodule

>>> hdl/sida_queue.sv
// ----------------------------------------------------------------------------
// sida_queue: number queue
// Short FIFO of converted numbers between the front and the back, so that
// conversion of the next number overlaps printing of the current one.
// ----------------------------------------------------------------------------
module sida_queue #(
  parameter int DEPTH = sida_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sida_pkg::sida_entry_t  push_entry,
  output logic                   full,
  input  logic                   pop,
  output sida_pkg::sida_entry_t  pop_entry,
  output logic                   empty
);
  import sida_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sida_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

>>> hdl/sida_back.sv
// ----------------------------------------------------------------------------
// sida_back: character emitter
// Takes numbers from the queue, sends the sign if negative, then the digits,
// most significant first, one character per cycle, flagging the last.
// ----------------------------------------------------------------------------
module sida_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  sida_pkg::sida_entry_t         q_entry,
  output logic                          pop,
  output logic                          out_valid,
  output logic [sida_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_last
);
  import sida_pkg::*;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

  back_state_t                         state_r, state_nxt;
  logic                                sign_pend_r, sign_pend_nxt;
  logic [DIGIT_W-1:0]                  idx_r, idx_nxt;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_r, digits_nxt;
  logic                                valid_r, valid_nxt;
  logic [CHAR_W-1:0]                   char_r, char_nxt;
  logic                                last_r, last_nxt;

  logic final_char;

  assign final_char = (state_r == B_EMIT) && !sign_pend_r && (idx_r == '0);
  assign pop        = !q_empty && ((state_r == B_IDLE) || final_char);

  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

  // One character per cycle; a number is loaded when idle or on the final one
  always_comb begin
    state_nxt     = state_r;
    sign_pend_nxt = sign_pend_r;
    idx_nxt       = idx_r;
    digits_nxt    = digits_r;
    valid_nxt     = 1'b0;
    char_nxt      = char_r;
    last_nxt      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
      end
      B_EMIT: begin
        valid_nxt = 1'b1;
        if (sign_pend_r) begin
          char_nxt      = CHAR_MINUS;
          sign_pend_nxt = 1'b0;
        end else begin
          char_nxt = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_r[idx_r]};
          if (idx_r == '0) begin
            last_nxt  = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (pop) begin
      state_nxt     = B_EMIT;
      sign_pend_nxt = q_entry.neg;
      idx_nxt       = DIGIT_W'(q_entry.cnt - 1'b1);
      digits_nxt    = q_entry.digits;
    end
  end

  // Hold state and the registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      last_r      <= last_nxt;
      sign_pend_r <= sign_pend_nxt;
      idx_r       <= idx_nxt;
      digits_r    <= digits_nxt;
      char_r      <= char_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> valid_r)
    else $error("last flag without a character");
  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && char_r == CHAR_MINUS) |-> !last_r)
    else $error("sign emitted as last character");
`endif

endmodule

>>> hdl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top: signed 32-bit integer to decimal text
// Prints a signed value as ASCII, one character per strobed result.
// ----------------------------------------------------------------------------
// Pulse start with in_value while busy is low. The number's text comes out
// on out_char_code, one character per cycle with out_valid high for that
// cycle, sign first for a negative value, then digits most significant
// first, with out_last on the final character; the receiver must take every
// character as it appears. The front peels off the decimal digits in its
// divide-by-ten loop and then queues the number, waiting while the queue is
// full, so busy stays high from a start until the number is queued; the back
// emits one character per cycle.
module signed_int_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = sida_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sida_pkg::VALUE_W-1:0]  in_value,
  output logic                          busy,
  output logic                          out_valid,
  output logic [sida_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_last
);
  import sida_pkg::*;

  logic        push, pop, q_full, q_empty;
  sida_entry_t push_entry, pop_entry;

  // Intake and digit extraction
  sida_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_value   (in_value),
    .busy       (busy),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // Decouple conversion from printing
  sida_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // Character emission
  sida_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_entry       (pop_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule
